// File: rtl/idq_pkg.sv
package idq_pkg;

    // Fixed sizes of the dispatcher
    localparam int MAX_SERVERS = 16;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int RND_W       = 31;

    // Request codes
    localparam logic REQ_DISPATCH = 1'b0;
    localparam logic REQ_IDLE     = 1'b1;

    // Command from the dispatch control to the idle list
    typedef struct packed {
        logic             reload;
        logic             append;
        logic             remove;
        logic [CNT_W-1:0] count;   // new server count on reload, current one otherwise
        logic [ID_W-1:0]  sid;
        logic [ID_W-1:0]  pos;
    } t_list_cmd;

    // Status of the idle list
    typedef struct packed {
        logic             busy;
        logic             take;    // chosen is the removed entry in this cycle
        logic [ID_W-1:0]  chosen;
        logic [CNT_W-1:0] count;
    } t_list_sts;

endpackage

// File: rtl/idle_queue_dispatcher.sv
// Join-idle-queue dispatcher. A dispatch transaction (req_type 0) returns one
// result: an idle server taken from the list at position random_value mod the
// list length, or random_value mod server_count when the list is empty. An
// idle report (req_type 1) appends the server unless it is listed or out of
// range, and returns nothing. A dispatch result passes through the bit-serial
// remainder unit, a state that sees it finish, an issue state and, for a pick
// from the list, one list-memory read before it lands in the output register.
// The list shift-down of up to 15 entries (one per cycle through the single
// write port) overlaps the next item's remainder work; a result still waiting
// in the output register holds the next dispatch at issue. An idle report
// waits while the list is busy, as when it directly follows a dispatch whose
// shift-down is still running. After reset, and after each server_count
// write, the list memory is rewritten in a sweep over all 16 entries; items
// are accepted meanwhile and list updates wait for the sweep to end.
module idle_queue_dispatcher
    import idq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  logic [ID_W-1:0]  i_server_id,
    input  logic [RND_W-1:0] i_random_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ID_W-1:0]  o_chosen_server,
    output logic             o_from_idle_list
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REPORT = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_TAKE   = 3'd4;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SERVERS);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_server_count;
    logic [ID_W-1:0]  r_sid;
    logic             r_from_idle;
    logic             r_out_valid;
    logic [ID_W-1:0]  r_out_server;
    logic             r_out_from;

    logic             in_fire;
    logic             cfg_fire;
    logic [CNT_W-1:0] cfg_count;
    logic             out_free;
    logic             mod_start;
    logic [CNT_W-1:0] mod_divisor;
    logic             mod_busy;
    logic [CNT_W-1:0] mod_rem;
    logic             load_fallback;
    t_list_cmd        list_cmd;
    t_list_sts        list_sts;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign cfg_fire    = i_cfg_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Clamp the written server count to 1..MAX_SERVERS
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_count = CNT_W'(1);
        end else if (i_cfg_data > FULL_CNT) begin
            cfg_count = FULL_CNT;
        end else begin
            cfg_count = i_cfg_data;
        end
    end

    // Start the remainder on an accepted dispatch
    assign mod_start   = in_fire && (i_req_type == REQ_DISPATCH);
    assign mod_divisor = (list_sts.count == '0) ? r_server_count : list_sts.count;

    idq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_random_value),
        .i_divisor  (mod_divisor),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    // Sequence one transaction at a time
    always_comb begin
        n_state         = r_state;
        load_fallback   = 1'b0;
        list_cmd.reload = cfg_fire;
        list_cmd.append = 1'b0;
        list_cmd.remove = 1'b0;
        list_cmd.count  = cfg_fire ? cfg_count : r_server_count;
        list_cmd.sid    = r_sid;
        list_cmd.pos    = mod_rem[ID_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_req_type == REQ_IDLE) ? S_REPORT : S_DIV;
                end
            end
            S_REPORT: begin
                if (!list_sts.busy) begin
                    list_cmd.append = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIV: begin
                if (!mod_busy) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (out_free) begin
                    if (!r_from_idle) begin
                        load_fallback = 1'b1;
                        n_state       = S_IDLE;
                    end else if (!list_sts.busy) begin
                        list_cmd.remove = 1'b1;
                        n_state         = S_TAKE;
                    end
                end
            end
            S_TAKE: begin
                if (list_sts.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    idq_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (list_cmd),
        .o_sts   (list_sts)
    );

    // Control state and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_server_count <= FULL_CNT;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                r_server_count <= cfg_count;
            end
        end
    end

    // Hold the request details
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sid       <= i_server_id;
            r_from_idle <= (list_sts.count != '0);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_fallback || (r_state == S_TAKE && list_sts.take)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_fallback) begin
            r_out_server <= mod_rem[ID_W-1:0];
            r_out_from   <= 1'b0;
        end else if (r_state == S_TAKE && list_sts.take) begin
            r_out_server <= list_sts.chosen;
            r_out_from   <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_chosen_server  = r_out_server;
    assign o_from_idle_list = r_out_from;

endmodule

// File: rtl/idq_mod.sv
module idq_mod
    import idq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [CNT_W-1:0] o_rem
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RND_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [RND_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W:0]   trial;

    // Shift in one dividend bit per cycle
    assign trial = {r_rem, r_dvd[RND_W-1]};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= LAST_STEP;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Restoring remainder step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= CNT_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= CNT_W'(trial);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

// File: rtl/idq_list.sv
module idq_list
    import idq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_list_cmd i_cmd,
    output t_list_sts o_sts
);

    localparam logic [1:0] L_IDLE   = 2'd0;
    localparam logic [1:0] L_TAKE   = 2'd1;
    localparam logic [1:0] L_SHIFT  = 2'd2;
    localparam logic [1:0] L_RELOAD = 2'd3;

    localparam logic [ID_W-1:0]  LAST_ADDR = ID_W'(MAX_SERVERS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_SERVERS);

    logic [1:0]             r_state, n_state;
    logic [ID_W-1:0]        r_ptr, n_ptr;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MAX_SERVERS-1:0] r_listed, n_listed;

    logic [ID_W-1:0] mem [MAX_SERVERS];
    logic [ID_W-1:0] r_rd_data;
    logic            mem_we;
    logic [ID_W-1:0] mem_wa;
    logic [ID_W-1:0] mem_wd;
    logic [ID_W-1:0] mem_ra;
    logic [CNT_W-1:0] dec_count;

    assign dec_count = r_count - 1'b1;

    // Sequence reload sweep, append, and remove with shift-down
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_count  = r_count;
        n_listed = r_listed;
        mem_we   = 1'b0;
        mem_wa   = r_ptr;
        mem_wd   = r_rd_data;
        mem_ra   = r_ptr;
        unique case (r_state)
            L_IDLE: begin
                if (i_cmd.append) begin
                    if (!r_listed[i_cmd.sid] && ({1'b0, i_cmd.sid} < i_cmd.count)
                        && (r_count < FULL_CNT)) begin
                        mem_we                = 1'b1;
                        mem_wa                = r_count[ID_W-1:0];
                        mem_wd                = i_cmd.sid;
                        n_count               = r_count + 1'b1;
                        n_listed[i_cmd.sid]   = 1'b1;
                    end
                end else if (i_cmd.remove) begin
                    mem_ra  = i_cmd.pos;
                    n_ptr   = i_cmd.pos;
                    n_state = L_TAKE;
                end
            end
            L_TAKE: begin
                n_listed[r_rd_data] = 1'b0;
                n_count             = dec_count;
                if ({1'b0, r_ptr} < dec_count) begin
                    mem_ra  = r_ptr + 1'b1;
                    n_state = L_SHIFT;
                end else begin
                    n_state = L_IDLE;
                end
            end
            L_SHIFT: begin
                // Move the entry read last cycle down one place
                mem_we = 1'b1;
                mem_wa = r_ptr;
                mem_wd = r_rd_data;
                if (({1'b0, r_ptr} + 1'b1) < r_count) begin
                    mem_ra = r_ptr + 2'd2;
                    n_ptr  = r_ptr + 1'b1;
                end else begin
                    n_state = L_IDLE;
                end
            end
            L_RELOAD: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
                mem_wd = r_ptr;
                n_ptr  = r_ptr + 1'b1;
                if (r_ptr == LAST_ADDR) begin
                    n_state = L_IDLE;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase

        // Reload takes precedence and restarts the sweep
        if (i_cmd.reload) begin
            n_state = L_RELOAD;
            n_ptr   = '0;
            n_count = i_cmd.count;
            for (int i = 0; i < MAX_SERVERS; i++) begin
                n_listed[i] = (CNT_W'(i) < i_cmd.count);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_RELOAD;
            r_ptr    <= '0;
            r_count  <= FULL_CNT;
            r_listed <= '1;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_count  <= n_count;
            r_listed <= n_listed;
        end
    end

    // List memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    assign o_sts.busy   = (r_state != L_IDLE);
    assign o_sts.take   = (r_state == L_TAKE);
    assign o_sts.chosen = r_rd_data;
    assign o_sts.count  = r_count;

endmodule
